// ===== rtl/core/tjt_pkg.sv =====
// shared types and constants of the task timing jitter tracker
package tjt_pkg;

    localparam int TASK_COUNT_DEF = 8;
    localparam logic [15:0] JITTER_MAX = 16'hFFFF;

    localparam logic [1:0] MODE_ELAPSED = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  task_number;
        logic [15:0] elapsed_time;
        logic [31:0] now_time;
        logic [15:0] nominal_period;
    } req_t;

    typedef struct packed {
        logic        task_in_range;
        logic [15:0] peak_elapsed;
        logic [15:0] peak_jitter;
    } rsp_t;

    typedef struct packed {
        logic [15:0] peak_elapsed;
        logic [31:0] last_start;
        logic [15:0] peak_jitter;
        logic        start_seen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } state_t;

endpackage

// ===== rtl/core/task_timing_jitter_tracker.sv =====
// top level of the task timing jitter tracker: sequencer around one entry ram
//
// usage:
//   a request is taken at a rising edge with start high and busy low; req
//   carries mode, task number, elapsed time, timestamp and nominal period.
//   every request gives exactly one result: done is high for one cycle and
//   rsp holds in-range flag, peak elapsed and peak jitter after the update.
//   the receiver cannot stall; done drops after that cycle and rsp holds until the next result.
//   done is registered and rises after the write-back state; busy holds
//   off a new request until then. the accepting edge issues the ram read,
//   then busy covers the read state (read data and interval subtract), the
//   calc state (jitter subtract/saturate) and the entry write back state.
//   a new request may be taken in the same cycle that done is shown.
//   reset clears the per-entry valid flops at once; an entry never written
//   reads as all zeros, so the table needs no clearing pass.
//   out-of-range task numbers read and write nothing and report zeros.
module task_timing_jitter_tracker #(
    parameter int TASK_COUNT = tjt_pkg::TASK_COUNT_DEF,
    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tjt_pkg::req_t req,
    output logic          done,
    output tjt_pkg::rsp_t rsp
);

    tjt_pkg::state_t state_reg;
    tjt_pkg::state_t state_next;
    logic            done_reg;
    logic            done_next;
    logic [TASK_COUNT-1:0] valid_reg;
    logic [TASK_COUNT-1:0] valid_next;

    tjt_pkg::req_t   req_reg;
    logic            in_range_reg;
    tjt_pkg::entry_t entry_reg;
    tjt_pkg::entry_t entry_next;
    logic [31:0]     interval_reg;
    logic [31:0]     interval_next;
    logic [15:0]     jit_reg;
    logic [15:0]     jit_next;
    tjt_pkg::rsp_t   rsp_reg;
    tjt_pkg::rsp_t   rsp_next;

    logic                        accept;
    logic                        in_range_in;
    logic                        ram_rd_en;
    logic                        ram_wr_en;
    logic [IDX_W-1:0]            rd_idx;
    logic [IDX_W-1:0]            cur_idx;
    logic [tjt_pkg::ENTRY_W-1:0] ram_rd_data;
    tjt_pkg::entry_t             entry_upd;
    logic [31:0]                 nominal_ext;
    logic [31:0]                 diff;

    assign busy        = (state_reg != tjt_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign in_range_in = (req.task_number < 8'(TASK_COUNT));
    assign rd_idx      = req.task_number[IDX_W-1:0];
    assign cur_idx     = req_reg.task_number[IDX_W-1:0];
    assign ram_rd_en   = accept && in_range_in;
    assign nominal_ext = {16'd0, req_reg.nominal_period};

    tjt_ram #(
        .WIDTH(tjt_pkg::ENTRY_W),
        .DEPTH(TASK_COUNT)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(cur_idx),
        .wr_data(entry_upd),
        .rd_en  (ram_rd_en),
        .rd_addr(rd_idx),
        .rd_data(ram_rd_data)
    );

    // entry update, valid only in the write state
    always_comb
    begin
        entry_upd = entry_reg;
        case (req_reg.mode)
            tjt_pkg::MODE_ELAPSED:
            begin
                if (req_reg.elapsed_time > entry_reg.peak_elapsed)
                begin
                    entry_upd.peak_elapsed = req_reg.elapsed_time;
                end
            end
            tjt_pkg::MODE_START:
            begin
                if (entry_reg.start_seen && (jit_reg > entry_reg.peak_jitter))
                begin
                    entry_upd.peak_jitter = jit_reg;
                end
                entry_upd.last_start = req_reg.now_time;
                entry_upd.start_seen = 1'b1;
            end
            default:
            begin
                entry_upd = entry_reg;
            end
        endcase
    end

    always_comb
    begin
        if (interval_reg >= nominal_ext)
        begin
            diff = interval_reg - nominal_ext;
        end
        else
        begin
            diff = nominal_ext - interval_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        valid_next    = valid_reg;
        entry_next    = entry_reg;
        interval_next = interval_reg;
        jit_next      = jit_reg;
        rsp_next      = rsp_reg;
        ram_wr_en     = 1'b0;
        case (state_reg)
            tjt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tjt_pkg::ST_READ;
                end
            end
            tjt_pkg::ST_READ:
            begin
                // entries never written read as zero
                if (valid_reg[cur_idx])
                begin
                    entry_next = tjt_pkg::entry_t'(ram_rd_data);
                end
                else
                begin
                    entry_next = '0;
                end
                interval_next = req_reg.now_time - entry_next.last_start;
                state_next    = tjt_pkg::ST_CALC;
            end
            tjt_pkg::ST_CALC:
            begin
                jit_next   = (diff[31:16] != 16'd0) ? tjt_pkg::JITTER_MAX : diff[15:0];
                state_next = tjt_pkg::ST_WRITE;
            end
            tjt_pkg::ST_WRITE:
            begin
                ram_wr_en = in_range_reg &&
                            (req_reg.mode inside {tjt_pkg::MODE_ELAPSED, tjt_pkg::MODE_START});
                if (ram_wr_en)
                begin
                    valid_next[cur_idx] = 1'b1;
                end
                if (in_range_reg)
                begin
                    rsp_next.task_in_range = 1'b1;
                    rsp_next.peak_elapsed  = entry_upd.peak_elapsed;
                    rsp_next.peak_jitter   = entry_upd.peak_jitter;
                end
                else
                begin
                    rsp_next = '0;
                end
                done_next  = 1'b1;
                state_next = tjt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tjt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tjt_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req;
            in_range_reg <= in_range_in;
        end
        entry_reg    <= entry_next;
        interval_reg <= interval_next;
        jit_reg      <= jit_next;
        rsp_reg      <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == tjt_pkg::ST_WRITE))
        else $error("result strobe without a write-back cycle");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !rsp_reg.task_in_range) |->
            (rsp_reg.peak_elapsed == 16'd0 && rsp_reg.peak_jitter == 16'd0))
        else $error("out-of-range result carries nonzero peaks");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (in_range_reg && state_reg == tjt_pkg::ST_WRITE))
        else $error("table write for an out-of-range task");

    a_read_then_seq: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |=> (state_reg == tjt_pkg::ST_READ))
        else $error("ram read not followed by the read state");

endmodule

// ===== rtl/core/tjt_ram.sv =====
// generic single-port-write, registered-read ram
module tjt_ram #(
    parameter int WIDTH = tjt_pkg::ENTRY_W,
    parameter int DEPTH = tjt_pkg::TASK_COUNT_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
